[rtl/dmv_pkg.sv]
// ----------------------------------------------------------------------------
// dmv_pkg
// Shared types and constants for the DNS message validator.
// ----------------------------------------------------------------------------
package dmv_pkg;

    localparam int OFS_W = 18;

    localparam logic [15:0] TYPE_OPT  = 16'd41;
    localparam logic [15:0] TYPE_TSIG = 16'd250;
    localparam logic [15:0] TYPE_SIG  = 16'd24;
    localparam logic [1:0]  TAG_LABEL = 2'b00;
    localparam logic [1:0]  TAG_PTR   = 2'b11;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_FORMERR = 2'd1,
        STATUS_REFUSED = 2'd2,
        STATUS_NOTIMPL = 2'd3
    } dmv_status_t;

    typedef enum logic [2:0] {
        RD_CUR  = 3'd0,
        RD_CUR1 = 3'd1,
        RD_WO   = 3'd2,
        RD_WO1  = 3'd3,
        RD_WO8  = 3'd4,
        RD_WO9  = 3'd5
    } dmv_rd_sel_t;

    typedef enum logic [2:0] {
        CAP_NONE = 3'd0,
        CAP_T_HI = 3'd1,
        CAP_T_LO = 3'd2,
        CAP_L_HI = 3'd3,
        CAP_L_LO = 3'd4
    } dmv_cap_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] query_length;
    } dmv_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] end_offset;
        logic        opt_found;
        logic [15:0] opt_start;
        logic [15:0] opt_fixed;
        logic [15:0] opt_length;
        logic [15:0] transaction_id;
    } dmv_rsp_t;

    typedef struct packed {
        logic        load;
        logic        start;
        logic        sec_next;
        logic        rec_begin;
        logic        label_adv;
        logic        name_end;
        logic        ptr_hold;
        logic        ptr_follow;
        logic        q_adv;
        logic        rec_adv;
        logic        opt_rec;
        logic        finish;
        dmv_status_t fin_status;
        logic        emit;
        dmv_rd_sel_t rd_sel;
        dmv_cap_t    cap;
    } dmv_cmd_t;

    typedef struct packed {
        logic       hdr_bad;
        logic       rl_zero;
        logic       sec_last;
        logic       sec_question;
        logic       cur_ge_len;
        logic       b_zero;
        logic [1:0] b_tag;
        logic       label_over;
        logic       ptr_cur_over;
        logic       ptr_ge_len;
        logic       hop_max;
        logic       q_over;
        logic       r_over;
        logic       stop_over;
        logic       type_opt;
        logic       type_tsig;
        logic       type_sig;
        logic       opt_seen;
        logic       qlen_match;
        logic       query_mode;
        logic       out_free;
    } dmv_stat_t;

endpackage

[rtl/dmv_ctrl.sv]
// ----------------------------------------------------------------------------
// dmv_ctrl
// Sequencer for load, header check, name walk and record checks.
// ----------------------------------------------------------------------------
module dmv_ctrl
    import dmv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      last_byte,
    output logic      req_stall,
    input  dmv_stat_t stat,
    output dmv_cmd_t  cmd
);

    typedef enum logic [12:0] {
        S_LOAD  = 13'b0000000000001,
        S_START = 13'b0000000000010,
        S_REC   = 13'b0000000000100,
        S_NAME  = 13'b0000000001000,
        S_LABEL = 13'b0000000010000,
        S_PTR   = 13'b0000000100000,
        S_FIX   = 13'b0000001000000,
        S_T0    = 13'b0000010000000,
        S_T1    = 13'b0000100000000,
        S_T2    = 13'b0001000000000,
        S_T3    = 13'b0010000000000,
        S_EVAL  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } dmv_state_t;

    dmv_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_stall = (state_reg != S_LOAD);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.fin_status = STATUS_FORMERR;
        cmd.rd_sel = RD_CUR;
        cmd.cap    = CAP_NONE;
        case (state_reg)
            S_LOAD:
            begin
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    if (last_byte)
                        state_next = S_START;
                end
            end
            S_START:
            begin
                if (stat.hdr_bad)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = S_REC;
                end
            end
            S_REC:
            begin
                if (stat.rl_zero)
                begin
                    if (stat.sec_last)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = STATUS_OK;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        cmd.sec_next = 1'b1;
                    end
                end
                else
                begin
                    cmd.rec_begin = 1'b1;
                    state_next    = S_NAME;
                end
            end
            S_NAME:
            begin
                // fetch the byte under the cursor
                if (stat.cur_ge_len)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = RD_CUR;
                    state_next = S_LABEL;
                end
            end
            S_LABEL:
            begin
                if (stat.b_tag == TAG_LABEL)
                begin
                    if (stat.b_zero)
                    begin
                        cmd.name_end = 1'b1;
                        state_next   = S_FIX;
                    end
                    else if (stat.label_over)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.label_adv = 1'b1;
                        state_next    = S_NAME;
                    end
                end
                else if (stat.b_tag == TAG_PTR)
                begin
                    if (stat.ptr_cur_over)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.ptr_hold = 1'b1;
                        cmd.rd_sel   = RD_CUR1;
                        state_next   = S_PTR;
                    end
                end
                else
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = STATUS_NOTIMPL;
                    state_next     = S_DONE;
                end
            end
            S_PTR:
            begin
                if (stat.ptr_ge_len || stat.hop_max)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.ptr_follow = 1'b1;
                    state_next     = S_NAME;
                end
            end
            S_FIX:
            begin
                if (stat.sec_question)
                begin
                    if (stat.q_over)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.q_adv  = 1'b1;
                        state_next = S_REC;
                    end
                end
                else if (stat.r_over)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = RD_WO;
                    state_next = S_T0;
                end
            end
            S_T0:
            begin
                cmd.cap    = CAP_T_HI;
                cmd.rd_sel = RD_WO1;
                state_next = S_T1;
            end
            S_T1:
            begin
                cmd.cap    = CAP_T_LO;
                cmd.rd_sel = RD_WO8;
                state_next = S_T2;
            end
            S_T2:
            begin
                cmd.cap    = CAP_L_HI;
                cmd.rd_sel = RD_WO9;
                state_next = S_T3;
            end
            S_T3:
            begin
                cmd.cap    = CAP_L_LO;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_DONE;
                cmd.finish = 1'b1;
                if (stat.stop_over)
                begin
                    cmd.fin_status = STATUS_FORMERR;
                end
                else if (stat.type_opt)
                begin
                    if (!stat.sec_last || (stat.query_mode && stat.opt_seen))
                    begin
                        cmd.fin_status = STATUS_FORMERR;
                    end
                    else
                    begin
                        cmd.finish  = 1'b0;
                        cmd.opt_rec = stat.query_mode;
                        cmd.rec_adv = 1'b1;
                        state_next  = S_REC;
                    end
                end
                else if (stat.type_tsig && stat.query_mode)
                begin
                    if (!stat.sec_last || !stat.qlen_match)
                        cmd.fin_status = STATUS_FORMERR;
                    else
                        cmd.fin_status = STATUS_REFUSED;
                end
                else if (stat.type_sig && stat.query_mode)
                begin
                    cmd.fin_status = STATUS_REFUSED;
                end
                else
                begin
                    cmd.finish  = 1'b0;
                    cmd.rec_adv = 1'b1;
                    state_next  = S_REC;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

[rtl/dmv_datapath.sv]
// ----------------------------------------------------------------------------
// dmv_datapath
// Message buffer, walk registers, checks and the result register.
// ----------------------------------------------------------------------------
module dmv_datapath
    import dmv_pkg::*;
#(
    parameter int MAX_LEN  = 4096,
    parameter int MAX_HOPS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  dmv_req_t  req,
    input  logic      cfg_valid,
    input  logic      cfg_data,
    input  logic      rsp_stall,
    output logic      rsp_valid,
    output dmv_rsp_t  rsp,
    input  dmv_cmd_t  cmd,
    output dmv_stat_t stat
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 2);
    localparam int HW = $clog2(MAX_HOPS + 1);

    logic [7:0]       mem [0:MAX_LEN-1];
    logic [7:0]       hdr_reg [0:11];
    logic [7:0]       rdata_reg;
    logic [CW-1:0]    bc_reg;
    logic [CW-1:0]    bc_inc;
    logic [OFS_W-1:0] len_reg;
    logic [15:0]      qlen_reg;
    logic             over_reg;
    logic             qm_reg;
    logic [OFS_W-1:0] wo_reg, np_reg, cur_reg, end_reg;
    logic             jumped_reg;
    logic [HW-1:0]    hop_reg;
    logic [1:0]       sec_reg;
    logic [15:0]      rl_reg;
    logic [7:0]       b_reg;
    logic [15:0]      type_reg, rdlen_reg;
    logic             opt_seen_reg;
    logic [15:0]      opt_start_reg, opt_fixed_reg, opt_len_reg;
    dmv_status_t      fin_reg;
    logic             rsp_valid_reg;
    dmv_rsp_t         rsp_reg;

    logic [OFS_W-1:0] rd_addr;
    logic [OFS_W-1:0] stop;
    logic [15:0]      sec_count;
    logic [15:0]      next_count;
    logic [OFS_W-1:0] ptr;
    logic             show;

    assign bc_inc = (bc_reg <= CW'(MAX_LEN)) ? bc_reg + 1'b1 : bc_reg;
    assign stop   = wo_reg + OFS_W'(10) + OFS_W'(rdlen_reg);
    assign ptr    = OFS_W'({b_reg[5:0], rdata_reg});

    always_comb
    begin
        case (sec_reg)
            2'd0:    sec_count = {hdr_reg[4], hdr_reg[5]};
            2'd1:    sec_count = {hdr_reg[6], hdr_reg[7]};
            2'd2:    sec_count = {hdr_reg[8], hdr_reg[9]};
            default: sec_count = {hdr_reg[10], hdr_reg[11]};
        endcase
        case (sec_reg)
            2'd0:    next_count = {hdr_reg[6], hdr_reg[7]};
            2'd1:    next_count = {hdr_reg[8], hdr_reg[9]};
            default: next_count = {hdr_reg[10], hdr_reg[11]};
        endcase
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_CUR:  rd_addr = cur_reg;
            RD_CUR1: rd_addr = cur_reg + 1'b1;
            RD_WO:   rd_addr = wo_reg;
            RD_WO1:  rd_addr = wo_reg + OFS_W'(1);
            RD_WO8:  rd_addr = wo_reg + OFS_W'(8);
            RD_WO9:  rd_addr = wo_reg + OFS_W'(9);
            default: rd_addr = cur_reg;
        endcase
    end

    // buffer: write while loading, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load && (bc_reg < CW'(MAX_LEN)))
            mem[bc_reg[AW-1:0]] <= req.data_byte;
        rdata_reg <= mem[rd_addr[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (bc_reg < CW'(12)))
            hdr_reg[bc_reg[3:0]] <= req.data_byte;
        if (cmd.load)
        begin
            len_reg  <= OFS_W'(bc_inc);
            over_reg <= (bc_inc > CW'(MAX_LEN));
            qlen_reg <= req.query_length;
        end
        if (cmd.ptr_hold)
            b_reg <= rdata_reg;
        case (cmd.cap)
            CAP_T_HI: type_reg[15:8]  <= rdata_reg;
            CAP_T_LO: type_reg[7:0]   <= rdata_reg;
            CAP_L_HI: rdlen_reg[15:8] <= rdata_reg;
            CAP_L_LO: rdlen_reg[7:0]  <= rdata_reg;
            default:  ;
        endcase
        if (cmd.rec_begin)
            np_reg <= wo_reg;
        if (cmd.opt_rec)
        begin
            opt_start_reg <= np_reg[15:0];
            opt_fixed_reg <= wo_reg[15:0];
            opt_len_reg   <= 16'(stop - np_reg);
        end
        if (cmd.finish)
            fin_reg <= cmd.fin_status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg       <= '0;
            qm_reg       <= 1'b1;
            wo_reg       <= OFS_W'(12);
            cur_reg      <= '0;
            end_reg      <= '0;
            jumped_reg   <= 1'b0;
            hop_reg      <= '0;
            sec_reg      <= '0;
            rl_reg       <= '0;
            opt_seen_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                qm_reg <= cfg_data;
            if (cmd.load)
                bc_reg <= bc_inc;
            if (cmd.start)
            begin
                wo_reg  <= OFS_W'(12);
                sec_reg <= 2'd0;
                rl_reg  <= sec_count;
            end
            if (cmd.sec_next)
            begin
                sec_reg <= sec_reg + 1'b1;
                rl_reg  <= next_count;
            end
            if (cmd.rec_begin)
            begin
                cur_reg    <= wo_reg;
                hop_reg    <= '0;
                jumped_reg <= 1'b0;
            end
            if (cmd.label_adv)
                cur_reg <= cur_reg + OFS_W'(rdata_reg) + 1'b1;
            if (cmd.name_end)
                wo_reg <= jumped_reg ? end_reg : cur_reg + 1'b1;
            if (cmd.ptr_follow)
            begin
                hop_reg <= hop_reg + 1'b1;
                if (!jumped_reg)
                begin
                    end_reg    <= cur_reg + OFS_W'(2);
                    jumped_reg <= 1'b1;
                end
                cur_reg <= ptr;
            end
            if (cmd.q_adv)
            begin
                wo_reg <= wo_reg + OFS_W'(4);
                rl_reg <= rl_reg - 1'b1;
            end
            if (cmd.rec_adv)
            begin
                wo_reg <= stop;
                rl_reg <= rl_reg - 1'b1;
            end
            if (cmd.opt_rec)
                opt_seen_reg <= 1'b1;
            if (cmd.emit)
            begin
                // drop the message state, ready for the next one
                bc_reg       <= '0;
                wo_reg       <= OFS_W'(12);
                sec_reg      <= '0;
                rl_reg       <= '0;
                cur_reg      <= '0;
                hop_reg      <= '0;
                opt_seen_reg <= 1'b0;
            end
        end
    end

    // result register
    assign show = (fin_reg == STATUS_OK) && qm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            rsp_reg.status         <= fin_reg;
            rsp_reg.end_offset     <= (fin_reg == STATUS_OK) ? wo_reg[15:0] : 16'd0;
            rsp_reg.opt_found      <= show && opt_seen_reg;
            rsp_reg.opt_start      <= (show && opt_seen_reg) ? opt_start_reg : 16'd0;
            rsp_reg.opt_fixed      <= (show && opt_seen_reg) ? opt_fixed_reg : 16'd0;
            rsp_reg.opt_length     <= (show && opt_seen_reg) ? opt_len_reg : 16'd0;
            rsp_reg.transaction_id <= show ? {hdr_reg[0], hdr_reg[1]} : 16'd0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        stat.hdr_bad      = over_reg || (len_reg < OFS_W'(12));
        stat.rl_zero      = (rl_reg == 16'd0);
        stat.sec_last     = (sec_reg == 2'd3);
        stat.sec_question = (sec_reg == 2'd0);
        stat.cur_ge_len   = (cur_reg >= len_reg);
        stat.b_zero       = (rdata_reg == 8'd0);
        stat.b_tag        = rdata_reg[7:6];
        stat.label_over   = (cur_reg + OFS_W'(rdata_reg) >= len_reg);
        stat.ptr_cur_over = (cur_reg + 1'b1 >= len_reg);
        stat.ptr_ge_len   = (ptr >= len_reg);
        stat.hop_max      = (hop_reg >= HW'(MAX_HOPS));
        stat.q_over       = (wo_reg + OFS_W'(4) > len_reg);
        stat.r_over       = (wo_reg + OFS_W'(10) > len_reg);
        stat.stop_over    = (stop > len_reg);
        stat.type_opt     = (type_reg == TYPE_OPT);
        stat.type_tsig    = (type_reg == TYPE_TSIG);
        stat.type_sig     = (type_reg == TYPE_SIG);
        stat.opt_seen     = opt_seen_reg;
        stat.qlen_match   = (stop == OFS_W'(qlen_reg));
        stat.query_mode   = qm_reg;
        stat.out_free     = !rsp_valid_reg || !rsp_stall;
    end

endmodule

[rtl/dns_message_validator.sv]
// Loading: one byte per cycle; after the last byte the walk steps through the
//   labels, pointers, question entries and record fixed parts of each section,
//   then loads the result into the output register.
// Throughput: one message at a time; bytes stall from the last byte until the
//   result is loaded into the output register. The single message buffer sets this.
// Reset: rst_n clears control state; query_mode comes up as 1.
// ----------------------------------------------------------------------------
// dns_message_validator
// Buffers a DNS message and checks its format, emitting one status beat.
// ----------------------------------------------------------------------------
module dns_message_validator
    import dmv_pkg::*;
#(
    parameter int MAX_LEN  = 4096,
    parameter int MAX_HOPS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  dmv_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output dmv_rsp_t rsp,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data
);

    dmv_cmd_t  cmd;
    dmv_stat_t stat;

    // the user must issue configuration writes only while idle; the block takes them always, unchecked
    assign cfg_ready = 1'b1;

    // sequencer: load beats, walk names and records, hand off the result
    dmv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .last_byte (req.last_byte),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // buffer, offsets, checks and the output register
    dmv_datapath #(
        .MAX_LEN  (MAX_LEN),
        .MAX_HOPS (MAX_HOPS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

[rtl/dmv_checker.sv]
// ----------------------------------------------------------------------------
// dmv_checker
// Port-level checks on the DNS message validator.
// ----------------------------------------------------------------------------
module dmv_checker
    import dmv_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input dmv_req_t req,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input dmv_rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    a_walk_stall: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req.last_byte |=> req_stall)
        else $error("input taken during message walk");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != STATUS_OK) |->
            (rsp.end_offset == 16'd0) && !rsp.opt_found && (rsp.transaction_id == 16'd0))
        else $error("failed result carries detail fields");

    a_opt_len: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.opt_found |-> (rsp.opt_length >= 16'd11))
        else $error("OPT record shorter than its fixed part");

endmodule

bind dns_message_validator dmv_checker u_dmv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
